// ===== rtl/uer_pkg.sv =====
`timescale 1ns / 1ps

package uer_pkg;

    // Field widths
    localparam int unsigned CountWidth  = 16;
    localparam int unsigned CfgWidth    = 16;
    localparam int unsigned CfgIdxWidth = 2;

    // Defaults
    localparam int unsigned TriggerTicksDefault = 10;
    localparam logic [CfgWidth-1:0] TimeoutReset  = 16'd30000;
    localparam logic [CfgWidth-1:0] MinCentiReset = 16'd200;
    localparam logic [CfgWidth-1:0] MaxCentiReset = 16'd40000;

    // Register indexes on the configuration port
    localparam logic [CfgIdxWidth-1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_MIN_CENTI = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_MAX_CENTI = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_RISE  = 2'd1;
    localparam logic [1:0] ST_NO_FALL  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // Scaled product width: a 16-bit width times 17
    localparam int unsigned ProdWidth  = 21;
    // Ten times a 16-bit limit
    localparam int unsigned LimitWidth = 20;
    // Reciprocal of ten, exact for products below 2**22
    localparam int unsigned Div10Shift = 24;
    localparam logic [ProdWidth-1:0] Div10Mul = 21'd1677722;

    typedef struct packed {
        logic [CfgWidth-1:0] timeout_us;
        logic [CfgWidth-1:0] min_centi;
        logic [CfgWidth-1:0] max_centi;
    } cfg_t;

    typedef struct packed {
        logic                  trig_out;
        logic                  busy_res;
        logic                  done_res;
        logic [1:0]            status;
        logic [CountWidth-1:0] distance_centi;
        logic [CountWidth-1:0] echo_width_us;
    } res_t;

endpackage

// ===== rtl/uer_range.sv =====
`timescale 1ns / 1ps

module uer_range
    import uer_pkg::*;
(
    input  logic [CountWidth-1:0] width_us,
    input  cfg_t                  cfg,
    output logic                  out_of_range,
    output logic [CountWidth-1:0] distance_centi
);

    logic [ProdWidth-1:0]            prod;
    logic [LimitWidth-1:0]           lo_lim;
    logic [LimitWidth-1:0]           hi_lim;
    logic [2*ProdWidth-1:0]          scaled;

    // Scale width by 17 with a shift and add
    assign prod = {1'b0, width_us, 4'b0000} + {{(ProdWidth-CountWidth){1'b0}}, width_us};

    // Limits times ten as shifts and adds
    assign lo_lim = {1'b0, cfg.min_centi, 3'b000} + {3'b000, cfg.min_centi, 1'b0};
    assign hi_lim = {1'b0, cfg.max_centi, 3'b000} + {3'b000, cfg.max_centi, 1'b0};

    assign out_of_range = (prod < {1'b0, lo_lim}) || (prod > {1'b0, hi_lim});

    // Divide by ten through the reciprocal
    assign scaled         = prod * Div10Mul;
    assign distance_centi = scaled[Div10Shift +: CountWidth];

endmodule

// ===== rtl/uer_core.sv =====
`timescale 1ns / 1ps

module uer_core
    import uer_pkg::*;
#(
    parameter int unsigned TRIGGER_TICKS = TriggerTicksDefault
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  logic start_req,
    input  logic echo,
    input  cfg_t cfg,
    output res_t res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_FALL
    } phase_t;

    localparam logic [CountWidth-1:0] TrigLimit = CountWidth'(TRIGGER_TICKS);
    localparam logic [CountWidth-1:0] CountMax  = {CountWidth{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [CountWidth-1:0] tick_reg, tick_next;
    logic [CountWidth-1:0] rise_reg, rise_next;
    res_t                  res_reg, res_next;

    logic [CountWidth-1:0] tick_inc;
    logic [CountWidth-1:0] width_us;
    logic                  out_of_range;
    logic [CountWidth-1:0] distance_centi;
    logic                  timed_out;

    // Saturating count and wait timeout
    assign tick_inc  = (tick_reg == CountMax) ? tick_reg : tick_reg + 1'b1;
    assign timed_out = tick_reg > cfg.timeout_us;
    assign width_us  = tick_reg - rise_reg;

    uer_range u_range (
        .width_us       (width_us),
        .cfg            (cfg),
        .out_of_range   (out_of_range),
        .distance_centi (distance_centi)
    );

    // One tick of the ranging sequence
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        rise_next  = rise_reg;
        res_next   = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    res_next.trig_out = 1'b1;
                    res_next.busy_res = 1'b1;
                    if (TrigLimit <= CountWidth'(1))
                    begin
                        phase_next = PH_RISE;
                        tick_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_TRIG;
                        tick_next  = CountWidth'(1);
                    end
                end
            end
            PH_TRIG:
            begin
                res_next.trig_out = 1'b1;
                res_next.busy_res = 1'b1;
                if (tick_inc >= TrigLimit)
                begin
                    phase_next = PH_RISE;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_RISE:
            begin
                res_next.busy_res = 1'b1;
                if (echo)
                begin
                    rise_next  = tick_reg;
                    phase_next = PH_FALL;
                    tick_next  = tick_inc;
                end
                else if (timed_out)
                begin
                    res_next.done_res = 1'b1;
                    res_next.status   = ST_NO_RISE;
                    phase_next        = PH_IDLE;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_FALL:
            begin
                res_next.busy_res = 1'b1;
                if (!echo)
                begin
                    res_next.done_res      = 1'b1;
                    res_next.echo_width_us = width_us;
                    if (out_of_range)
                    begin
                        res_next.status = ST_RANGE;
                    end
                    else
                    begin
                        res_next.status         = ST_OK;
                        res_next.distance_centi = distance_centi;
                    end
                    phase_next = PH_IDLE;
                end
                else if (timed_out)
                begin
                    res_next.done_res = 1'b1;
                    res_next.status   = ST_NO_FALL;
                    phase_next        = PH_IDLE;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Hold state and the result beat; advance only when the beat moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            rise_reg  <= '0;
            res_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            rise_reg  <= rise_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/ultrasonic_echo_ranger_top.sv =====
`timescale 1ns / 1ps

// Pulse-echo range finder clocked by one input beat per microsecond tick.
// Each input beat (start request and sampled echo level) gives exactly one
// result beat: trigger level, busy and done flags, status, distance in
// hundredths of a centimetre and echo width in ticks. A beat passes through
// an input register and then a result register, from which its result is
// offered to the output; one beat is accepted every cycle while the output
// side keeps taking results, the whole tick step being a single pass of the
// core logic. Write timeout_us, min_centi and max_centi (indexes 0 to 2) only
// while no beat is in flight; writes to index 3 are ignored.
module ultrasonic_echo_ranger_top
    import uer_pkg::*;
#(
    parameter int unsigned TRIGGER_TICKS = TriggerTicksDefault
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   start_req,
    input  logic                   echo,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   trig_out,
    output logic                   busy_res,
    output logic                   done_res,
    output logic [1:0]             status,
    output logic [CountWidth-1:0]  distance_centi,
    output logic [CountWidth-1:0]  echo_width_us,

    input  logic                   cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [CfgWidth-1:0]    cfg_wdata
);

    cfg_t cfg_reg;
    logic in_valid_reg;
    logic start_reg;
    logic echo_reg;
    logic out_valid_reg;
    logic advance;
    res_t res;

    // Move the held input beat into the result register when it is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_us <= TimeoutReset;
            cfg_reg.min_centi  <= MinCentiReset;
            cfg_reg.max_centi  <= MaxCentiReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT:   cfg_reg.timeout_us <= cfg_wdata;
                REG_MIN_CENTI: cfg_reg.min_centi  <= cfg_wdata;
                REG_MAX_CENTI: cfg_reg.max_centi  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            start_reg <= start_req;
            echo_reg  <= echo;
        end
    end

    // Result beat valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    uer_core #(
        .TRIGGER_TICKS (TRIGGER_TICKS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .start_req (start_reg),
        .echo      (echo_reg),
        .cfg       (cfg_reg),
        .res       (res)
    );

    assign out_valid      = out_valid_reg;
    assign trig_out       = res.trig_out;
    assign busy_res       = res.busy_res;
    assign done_res       = res.done_res;
    assign status         = res.status;
    assign distance_centi = res.distance_centi;
    assign echo_width_us  = res.echo_width_us;

endmodule

// ===== rtl/uer_checker.sv =====
`timescale 1ns / 1ps

module uer_checker
    import uer_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  trig_out,
    input logic                  busy_res,
    input logic                  done_res,
    input logic [1:0]            status,
    input logic [CountWidth-1:0] distance_centi,
    input logic [CountWidth-1:0] echo_width_us
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(distance_centi) && $stable(echo_width_us))
        else $error("result beat changed while stalled");

    // A finishing tick is part of a measurement and never drives the trigger
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res && !trig_out)
        else $error("done without busy or with trigger high");

    // Status, distance and width are quiet unless a measurement finishes
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == ST_OK && distance_centi == '0
            && echo_width_us == '0)
        else $error("result fields set without done");

    // Failed measurements report no distance
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> distance_centi == '0)
        else $error("distance reported on failure");

    // Timeouts report no width
    a_timeout_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_RISE || status == ST_NO_FALL)
            |-> echo_width_us == '0)
        else $error("width reported on timeout");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .trig_out       (trig_out),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .status         (status),
    .distance_centi (distance_centi),
    .echo_width_us  (echo_width_us)
);
